>>> rtl/core/i2crm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants of the I2C register master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

    localparam int MAX_BYTES = 16;
    localparam int BUF_AW    = $clog2(MAX_BYTES);

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_START_FAIL = 2'd1;
    localparam logic [1:0] ST_DEV_NACK_R = 2'd2;
    localparam logic [1:0] ST_NACK       = 2'd3;

    localparam logic [9:0] WAIT_TICKS_RST = 10'd200;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] dev_address;
        logic [7:0] reg_address;
        logic [4:0] length;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       done_res;
        logic [1:0] status;
        logic       busy_res;
    } t_out;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } t_wbuf_wr;

endpackage
`default_nettype wire

>>> rtl/core/i2crm_wbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2crm_wbuf
// Generic RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module i2crm_wbuf #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/core/i2crm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2crm_ctrl
// Bus sequencer: updates the transfer state once per item and forms the result.
// ----------------------------------------------------------------------------
module i2crm_ctrl
    import i2crm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [9:0]        i_cfg_wdata,
    input  wire logic              i_step,
    input  wire t_in               i_item,
    input  wire logic [7:0]        i_buf_rdata,
    output t_wbuf_wr               o_buf_wr,
    output logic [BUF_AW-1:0]      o_buf_raddr,
    output t_out                   o_res
);

    localparam logic [4:0] P_IDLE     = 5'd0;
    localparam logic [4:0] P_ST_A     = 5'd1;
    localparam logic [4:0] P_ST_B     = 5'd2;
    localparam logic [4:0] P_ST_C     = 5'd3;
    localparam logic [4:0] P_TX_LOW   = 5'd4;
    localparam logic [4:0] P_TX_HIGH  = 5'd5;
    localparam logic [4:0] P_ACK_HIGH = 5'd6;
    localparam logic [4:0] P_ACK_LOW  = 5'd7;
    localparam logic [4:0] P_SP_A     = 5'd8;
    localparam logic [4:0] P_SP_B     = 5'd9;
    localparam logic [4:0] P_RX_LOW   = 5'd10;
    localparam logic [4:0] P_RX_HIGH  = 5'd11;
    localparam logic [4:0] P_RX_END   = 5'd12;
    localparam logic [4:0] P_AK_A     = 5'd13;
    localparam logic [4:0] P_AK_B     = 5'd14;
    localparam logic [4:0] P_NK_A     = 5'd15;
    localparam logic [4:0] P_NK_B     = 5'd16;

    localparam logic [1:0] S_DEV  = 2'd0;
    localparam logic [1:0] S_REG  = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;
    localparam logic [1:0] S_RDEV = 2'd3;

    localparam logic [4:0] MAX_LEN = 5'(MAX_BYTES);

    logic [9:0] r_wait_ticks;
    logic [4:0] r_phase, n_phase;
    logic [9:0] r_wait_count, n_wait_count;
    logic [2:0] r_bit_count, n_bit_count;
    logic [4:0] r_byte_count, n_byte_count;
    logic [7:0] r_shift, n_shift;
    logic [4:0] r_fill, n_fill;
    logic [7:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic [4:0] r_len, n_len;
    logic       r_is_read, n_is_read;
    logic [1:0] r_stage, n_stage;
    logic [1:0] r_err, n_err;

    logic [4:0] byte_inc;

    assign byte_inc    = r_byte_count + 5'd1;
    assign o_buf_raddr = (r_stage == S_DATA) ? byte_inc[BUF_AW-1:0] : '0;

    always_comb begin
        logic [10:0] cnt_inc;
        logic        fire;
        logic        do_ack;
        logic        ack;
        logic        do_nwd;
        logic        do_send;
        logic [7:0]  send_val;
        logic        last;
        logic        scl;
        logic        sda;

        n_phase      = r_phase;
        n_wait_count = r_wait_count;
        n_bit_count  = r_bit_count;
        n_byte_count = r_byte_count;
        n_shift      = r_shift;
        n_fill       = r_fill;
        n_dev        = r_dev;
        n_reg        = r_reg;
        n_len        = r_len;
        n_is_read    = r_is_read;
        n_stage      = r_stage;
        n_err        = r_err;
        o_buf_wr     = '{we: 1'b0, addr: r_fill[BUF_AW-1:0], data: i_item.data_byte};
        o_res        = '0;
        cnt_inc      = {1'b0, r_wait_count} + 11'd1;
        fire         = cnt_inc >= {1'b0, r_wait_ticks};
        do_ack       = 1'b0;
        ack          = 1'b0;
        do_nwd       = 1'b0;
        do_send      = 1'b0;
        send_val     = '0;
        last         = 1'b0;

        if (i_item.op == OP_LOAD) begin
            if (r_phase == P_IDLE && r_fill < MAX_LEN) begin
                o_buf_wr.we = 1'b1;
                n_fill      = r_fill + 5'd1;
            end
        end else if (i_item.op == OP_WRITE || i_item.op == OP_READ) begin
            if (r_phase == P_IDLE) begin
                n_dev        = i_item.dev_address;
                n_reg        = i_item.reg_address;
                n_len        = (i_item.length > MAX_LEN) ? MAX_LEN : i_item.length;
                n_is_read    = (i_item.op == OP_READ);
                if (i_item.op == OP_WRITE) begin
                    n_fill = '0;
                end
                n_stage      = S_DEV;
                n_byte_count = '0;
                n_bit_count  = '0;
                n_err        = ST_OK;
                n_phase      = P_ST_A;
                n_wait_count = '0;
            end
        end else if (r_phase != P_IDLE) begin
            n_wait_count = cnt_inc[9:0];
            if (fire) begin
                n_wait_count = '0;
                case (r_phase)
                    P_ST_A: begin
                        if (i_item.sda_in) begin
                            n_phase = P_ST_B;
                        end else if (r_stage == S_RDEV) begin
                            do_send  = 1'b1;
                            send_val = r_dev | 8'h01;
                        end else begin
                            n_phase         = P_IDLE;
                            o_res.done_res  = 1'b1;
                            o_res.status    = ST_START_FAIL;
                        end
                    end
                    P_ST_B: n_phase = P_ST_C;
                    P_ST_C: begin
                        do_send  = 1'b1;
                        send_val = (r_stage == S_RDEV) ? (r_dev | 8'h01) : r_dev;
                    end
                    P_TX_LOW: n_phase = P_TX_HIGH;
                    P_TX_HIGH: begin
                        if (r_bit_count == 3'd7) begin
                            n_phase = P_ACK_HIGH;
                        end else begin
                            n_bit_count = r_bit_count + 3'd1;
                            n_shift     = {r_shift[6:0], 1'b0};
                            n_phase     = P_TX_LOW;
                        end
                    end
                    P_ACK_HIGH: begin
                        if (i_item.sda_in) begin
                            do_ack = 1'b1;
                        end else begin
                            n_phase = P_ACK_LOW;
                        end
                    end
                    P_ACK_LOW: begin
                        do_ack = 1'b1;
                        ack    = 1'b1;
                    end
                    P_SP_A: n_phase = P_SP_B;
                    P_SP_B: begin
                        n_phase        = P_IDLE;
                        o_res.done_res = 1'b1;
                        o_res.status   = r_err;
                    end
                    P_RX_LOW: n_phase = P_RX_HIGH;
                    P_RX_HIGH: begin
                        n_shift = {r_shift[6:0], i_item.sda_in};
                        if (r_bit_count == 3'd7) begin
                            n_phase = P_RX_END;
                        end else begin
                            n_bit_count = r_bit_count + 3'd1;
                            n_phase     = P_RX_LOW;
                        end
                    end
                    P_RX_END: begin
                        last           = ({1'b0, byte_inc} >= {1'b0, r_len});
                        o_res.rx_valid = 1'b1;
                        o_res.rx_byte  = r_shift;
                        o_res.rx_last  = last;
                        n_byte_count   = byte_inc;
                        n_phase        = last ? P_NK_A : P_AK_A;
                    end
                    P_AK_A: n_phase = P_AK_B;
                    P_AK_B: begin
                        n_bit_count = '0;
                        n_shift     = '0;
                        n_phase     = P_RX_LOW;
                    end
                    P_NK_A: n_phase = P_NK_B;
                    P_NK_B: n_phase = P_SP_A;
                    default: n_phase = P_IDLE;
                endcase

                if (do_ack) begin
                    case (r_stage)
                        S_DEV: begin
                            if (!ack) begin
                                n_err   = r_is_read ? ST_DEV_NACK_R : ST_NACK;
                                n_phase = P_SP_A;
                            end else begin
                                n_stage  = S_REG;
                                do_send  = 1'b1;
                                send_val = r_reg;
                            end
                        end
                        S_REG: begin
                            if (!ack) begin
                                n_err   = ST_NACK;
                                n_phase = P_SP_A;
                            end else if (r_is_read) begin
                                n_stage = S_RDEV;
                                n_phase = P_ST_A;
                            end else begin
                                n_stage      = S_DATA;
                                n_byte_count = '0;
                                do_nwd       = 1'b1;
                            end
                        end
                        S_DATA: begin
                            n_byte_count = byte_inc;
                            do_nwd       = 1'b1;
                        end
                        default: begin
                            n_byte_count = '0;
                            n_bit_count  = '0;
                            n_shift      = '0;
                            n_phase      = (r_len != 5'd0) ? P_RX_LOW : P_NK_A;
                        end
                    endcase
                end

                if (do_nwd) begin
                    if (n_byte_count < r_len && n_byte_count < MAX_LEN) begin
                        do_send  = 1'b1;
                        send_val = i_buf_rdata;
                    end else begin
                        n_err   = ST_OK;
                        n_phase = P_SP_A;
                    end
                end

                if (do_send) begin
                    n_shift     = send_val;
                    n_bit_count = '0;
                    n_phase     = P_TX_LOW;
                end
            end
        end

        case (n_phase)
            P_ST_B:    begin scl = 1'b1; sda = 1'b0;       end
            P_ST_C:    begin scl = 1'b0; sda = 1'b0;       end
            P_TX_LOW:  begin scl = 1'b0; sda = n_shift[7]; end
            P_TX_HIGH: begin scl = 1'b1; sda = n_shift[7]; end
            P_ACK_LOW: begin scl = 1'b0; sda = 1'b1;       end
            P_SP_A:    begin scl = 1'b0; sda = 1'b0;       end
            P_SP_B:    begin scl = 1'b1; sda = 1'b0;       end
            P_RX_LOW:  begin scl = 1'b0; sda = 1'b1;       end
            P_RX_END:  begin scl = 1'b0; sda = 1'b1;       end
            P_AK_A:    begin scl = 1'b0; sda = 1'b0;       end
            P_AK_B:    begin scl = 1'b1; sda = 1'b0;       end
            P_NK_A:    begin scl = 1'b0; sda = 1'b1;       end
            default:   begin scl = 1'b1; sda = 1'b1;       end
        endcase
        o_res.scl_level = scl;
        o_res.sda_level = sda;
        o_res.busy_res  = (n_phase != P_IDLE);

        if (!i_step) begin
            o_buf_wr.we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= WAIT_TICKS_RST;
        end else if (i_cfg_we) begin
            r_wait_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= P_IDLE;
            r_wait_count <= '0;
            r_bit_count  <= '0;
            r_byte_count <= '0;
            r_shift      <= '0;
            r_fill       <= '0;
            r_dev        <= '0;
            r_reg        <= '0;
            r_len        <= '0;
            r_is_read    <= 1'b0;
            r_stage      <= S_DEV;
            r_err        <= ST_OK;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_wait_count <= n_wait_count;
            r_bit_count  <= n_bit_count;
            r_byte_count <= n_byte_count;
            r_shift      <= n_shift;
            r_fill       <= n_fill;
            r_dev        <= n_dev;
            r_reg        <= n_reg;
            r_len        <= n_len;
            r_is_read    <= n_is_read;
            r_stage      <= n_stage;
            r_err        <= n_err;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/i2c_register_master.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_master
// Open-drain I2C master for register writes and reads, timed by tick items.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one result transfer. The block takes one
// item per clock when neither side stalls: an input register feeds the
// sequencer, whose single state update per item lands in an output register.
// Only tick items move the bus; each wait phase spans wait_ticks ticks (zero
// acts as one). Load items fill a 16-byte write buffer while idle; a write
// start empties it.
// ----------------------------------------------------------------------------
module i2c_register_master
    import i2crm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [9:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in        i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out            o_out
);

    logic              r_in_valid;
    t_in               r_in;
    logic              r_out_valid;
    t_out              r_out;
    logic              advance;
    logic              step;
    t_wbuf_wr          buf_wr;
    logic [BUF_AW-1:0] buf_raddr;
    logic [7:0]        buf_rdata;
    t_out              res;

    assign advance     = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    i2crm_wbuf #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (buf_wr.we),
        .i_waddr (buf_wr.addr),
        .i_wdata (buf_wr.data),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    i2crm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_item      (r_in),
        .i_buf_rdata (buf_rdata),
        .o_buf_wr    (buf_wr),
        .o_buf_raddr (buf_raddr),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C register master. A directed table covers
// reset timing, ignored loads and starts, buffer overflow, length saturation,
// start failure, address nacks, unchecked acks and zero-length reads; random
// register transactions follow, answered by a behavioral bus slave. Every
// result is checked against a cycle-free sequencer model or a table value.
// ----------------------------------------------------------------------------
module tb_top;
    import i2crm_pkg::*;

    localparam int ITEMS_TARGET = 1300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 80;

    localparam t_out IDLE_PINS = '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0};
    localparam t_out BUSY_PINS = '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b1};
    localparam t_out START_FAILED =
        '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, ST_START_FAIL, 1'b0};

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TX_LOW, PH_TX_HIGH, PH_ACK_HIGH,
        PH_ACK_LOW, PH_SP_A, PH_SP_B, PH_RX_LOW, PH_RX_HIGH, PH_RX_END, PH_AK_A,
        PH_AK_B, PH_NK_A, PH_NK_B
    } t_bus_phase;

    typedef enum logic [1:0] {SG_DEV, SG_REG, SG_DATA, SG_RDEV} t_byte_stage;

    typedef enum logic [2:0] {
        SDA_LOW, SDA_HIGH, SDA_ACK, SDA_ACK_ADDR, SDA_ACK_DEV
    } t_sda_mode;

    typedef struct {
        bit        is_cfg;
        t_in       item;
        int        reps;
        t_sda_mode mode;
        bit        typed;
        t_out      want;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [9:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in        i_in;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out       o_out;

    i2c_register_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // sequencer model state
    t_bus_phase  ph;
    t_byte_stage stg;
    int          wcnt, bitn, nbytes, fill, len_q, cfg_ticks;
    logic [7:0]  shreg, dev_q, reg_q;
    logic [7:0]  wbuf [MAX_BYTES];
    bit          rd;
    logic [1:0]  err;

    t_out        pending_results [$];
    int          errors;
    int          quiet_cycles;
    int          work_items;
    bit          hold_req;
    bit          steady;
    bit          cur_typed;
    t_out        cur_want;
    t_stim_row   rows [$];

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
        errors++;
    endtask

    function automatic void go_to(t_bus_phase p);
        ph   = p;
        wcnt = 0;
    endfunction

    function automatic void send_out(logic [7:0] b);
        shreg = b;
        bitn  = 0;
        go_to(PH_TX_LOW);
    endfunction

    function automatic void stop_with(logic [1:0] code);
        err = code;
        go_to(PH_SP_A);
    endfunction

    function automatic void next_tx_data();
        if (nbytes < len_q && nbytes < MAX_BYTES) begin
            send_out(wbuf[nbytes]);
        end else begin
            stop_with(ST_OK);
        end
    endfunction

    function automatic void take_ack(bit ack);
        case (stg)
            SG_DEV: begin
                if (!ack) begin
                    stop_with(rd ? ST_DEV_NACK_R : ST_NACK);
                end else begin
                    stg = SG_REG;
                    send_out(reg_q);
                end
            end
            SG_REG: begin
                if (!ack) begin
                    stop_with(ST_NACK);
                end else if (rd) begin
                    stg = SG_RDEV;
                    go_to(PH_ST_A);
                end else begin
                    stg    = SG_DATA;
                    nbytes = 0;
                    next_tx_data();
                end
            end
            SG_DATA: begin
                nbytes++;
                next_tx_data();
            end
            default: begin
                nbytes = 0;
                bitn   = 0;
                shreg  = '0;
                go_to(len_q > 0 ? PH_RX_LOW : PH_NK_A);
            end
        endcase
    endfunction

    function automatic t_out master_step(t_in it);
        t_out r;
        r = '0;
        if (it.op == OP_LOAD) begin
            if (ph == PH_IDLE && fill < MAX_BYTES) begin
                wbuf[fill] = it.data_byte;
                fill++;
            end
        end else if (it.op == OP_WRITE || it.op == OP_READ) begin
            if (ph == PH_IDLE) begin
                dev_q  = it.dev_address;
                reg_q  = it.reg_address;
                len_q  = it.length > MAX_BYTES ? MAX_BYTES : it.length;
                rd     = (it.op == OP_READ);
                if (!rd) fill = 0;
                stg    = SG_DEV;
                nbytes = 0;
                bitn   = 0;
                err    = ST_OK;
                go_to(PH_ST_A);
            end
        end else if (ph != PH_IDLE) begin
            wcnt++;
            if (wcnt >= cfg_ticks) begin
                case (ph)
                    PH_ST_A: begin
                        if (it.sda_in) begin
                            go_to(PH_ST_B);
                        end else if (stg == SG_RDEV) begin
                            send_out(dev_q | 8'h01);
                        end else begin
                            go_to(PH_IDLE);
                            r.done_res = 1'b1;
                            r.status   = ST_START_FAIL;
                        end
                    end
                    PH_ST_B: go_to(PH_ST_C);
                    PH_ST_C: send_out(stg == SG_RDEV ? (dev_q | 8'h01) : dev_q);
                    PH_TX_LOW: go_to(PH_TX_HIGH);
                    PH_TX_HIGH: begin
                        if (bitn >= 7) begin
                            go_to(PH_ACK_HIGH);
                        end else begin
                            bitn++;
                            shreg = shreg << 1;
                            go_to(PH_TX_LOW);
                        end
                    end
                    PH_ACK_HIGH: begin
                        if (it.sda_in) take_ack(1'b0);
                        else go_to(PH_ACK_LOW);
                    end
                    PH_ACK_LOW: take_ack(1'b1);
                    PH_SP_A: go_to(PH_SP_B);
                    PH_SP_B: begin
                        go_to(PH_IDLE);
                        r.done_res = 1'b1;
                        r.status   = err;
                    end
                    PH_RX_LOW: go_to(PH_RX_HIGH);
                    PH_RX_HIGH: begin
                        shreg = {shreg[6:0], it.sda_in};
                        if (bitn >= 7) begin
                            go_to(PH_RX_END);
                        end else begin
                            bitn++;
                            go_to(PH_RX_LOW);
                        end
                    end
                    PH_RX_END: begin
                        r.rx_valid = 1'b1;
                        r.rx_byte  = shreg;
                        r.rx_last  = (nbytes + 1 >= len_q);
                        nbytes++;
                        go_to(r.rx_last ? PH_NK_A : PH_AK_A);
                    end
                    PH_AK_A: go_to(PH_AK_B);
                    PH_AK_B: begin
                        bitn  = 0;
                        shreg = '0;
                        go_to(PH_RX_LOW);
                    end
                    PH_NK_A: go_to(PH_NK_B);
                    PH_NK_B: go_to(PH_SP_A);
                    default: go_to(PH_IDLE);
                endcase
            end
        end

        case (ph)
            PH_ST_B:    {r.scl_level, r.sda_level} = 2'b10;
            PH_ST_C:    {r.scl_level, r.sda_level} = 2'b00;
            PH_TX_LOW:  {r.scl_level, r.sda_level} = {1'b0, shreg[7]};
            PH_TX_HIGH: {r.scl_level, r.sda_level} = {1'b1, shreg[7]};
            PH_ACK_LOW: {r.scl_level, r.sda_level} = 2'b01;
            PH_SP_A:    {r.scl_level, r.sda_level} = 2'b00;
            PH_SP_B:    {r.scl_level, r.sda_level} = 2'b10;
            PH_RX_LOW:  {r.scl_level, r.sda_level} = 2'b01;
            PH_RX_END:  {r.scl_level, r.sda_level} = 2'b01;
            PH_AK_A:    {r.scl_level, r.sda_level} = 2'b00;
            PH_AK_B:    {r.scl_level, r.sda_level} = 2'b10;
            PH_NK_A:    {r.scl_level, r.sda_level} = 2'b01;
            default:    {r.scl_level, r.sda_level} = 2'b11;
        endcase
        r.busy_res = (ph != PH_IDLE);
        return r;
    endfunction

    // slave side of the bus: level it puts on SDA for the next tick
    function automatic bit line_level(t_sda_mode m);
        bit ack;
        case (m)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default: ;
        endcase
        ack = (m == SDA_ACK) || (stg == SG_DEV) || (m == SDA_ACK_ADDR && stg == SG_REG);
        case (ph)
            PH_ST_A:     return !(m == SDA_ACK_ADDR && stg == SG_RDEV);
            PH_ACK_HIGH: return !ack;
            default:     return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic t_stim_row row(logic [1:0] op, logic [7:0] dev, logic [7:0] rg,
                                      logic [4:0] len, logic [7:0] dat, int reps,
                                      t_sda_mode mode, bit typed = 1'b0,
                                      t_out want = '0);
        t_stim_row s;
        s.is_cfg = 1'b0;
        s.item   = '{op, dev, rg, len, dat, 1'b0};
        s.reps   = reps;
        s.mode   = mode;
        s.typed  = typed;
        s.want   = want;
        return s;
    endfunction

    function automatic t_stim_row cfg_row(int value);
        t_stim_row s;
        s        = row(OP_TICK, 8'h00, 8'h00, 5'd0, 8'h00, value, SDA_HIGH);
        s.is_cfg = 1'b1;
        return s;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out want;
        t_out got;
        bit   moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                got   = o_out;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", got, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.scl_level !== want.scl_level)
                        report_mismatch("scl_level", got.scl_level, want.scl_level);
                    if (got.sda_level !== want.sda_level)
                        report_mismatch("sda_level", got.sda_level, want.sda_level);
                    if (got.rx_valid !== want.rx_valid)
                        report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
                    if (got.rx_byte !== want.rx_byte)
                        report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
                    if (got.rx_last !== want.rx_last)
                        report_mismatch("rx_last", got.rx_last, want.rx_last);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                want  = master_step(i_in);
                if (cur_typed) want = cur_want;
                pending_results.push_back(want);
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        @(posedge i_rst_n);
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("tb_top: errors");
        $finish;
    end

    initial begin : receiver
        int stretch;
        int stall_pct;
        stretch     = 0;
        stall_pct   = 0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else begin
                if (stretch == 0) begin
                    stretch = $urandom_range(20, 120);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                stretch--;
                if (stall_pct > 0 && $urandom_range(0, 299) == 0) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(15, 40)) @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end else begin
                    i_out_stall <= ($urandom_range(0, 99) < stall_pct);
                end
            end
        end
    end

    // offer one transfer and hold it until taken
    task automatic offer(t_in it, bit typed = 1'b0, t_out want = '0);
        if (it.op == OP_TICK ? ph != PH_IDLE
                             : (ph == PH_IDLE && (it.op != OP_LOAD || fill < MAX_BYTES)))
            work_items++;
        i_in       <= it;
        i_in_valid <= 1'b1;
        cur_typed  <= typed;
        cur_want   <= want;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic pace();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (hold_req || steady || r < 70) n = 0;
        else if (r < 95) n = $urandom_range(1, 3);
        else n = $urandom_range(8, 30);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_wait_ticks(int value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[9:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_ticks = value;
    endtask

    task automatic run_row(t_stim_row s);
        t_in it;
        it = s.item;
        if (s.is_cfg) begin
            write_wait_ticks(s.reps);
        end else if (s.reps == 0) begin
            do begin
                it.sda_in = line_level(s.mode);
                offer(it);
                pace();
            end while (ph != PH_IDLE);
        end else begin
            for (int k = 1; k <= s.reps; k++) begin
                it.sda_in = line_level(s.mode);
                offer(it, s.typed && k == s.reps, s.want);
                pace();
            end
        end
    endtask

    task automatic run_transaction();
        t_in       it;
        int        n;
        int        r;
        t_sda_mode mode;
        n = ($urandom_range(0, 5) == 0) ? MAX_BYTES + 1 : $urandom_range(0, 5);
        repeat (n) begin
            it    = t_in'($urandom);
            it.op = OP_LOAD;
            offer(it);
            pace();
        end
        it    = t_in'($urandom);
        it.op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        r     = $urandom_range(0, 99);
        if (cfg_ticks > 2) it.length = 5'($urandom_range(0, 3));
        else if (r < 10) it.length = 5'($urandom_range(MAX_BYTES + 1, 31));
        else if (r < 20) it.length = 5'(MAX_BYTES);
        else if (r < 25) it.length = 5'($urandom_range(5, MAX_BYTES - 1));
        else it.length = 5'($urandom_range(0, 4));
        offer(it);
        pace();
        r = $urandom_range(0, 99);
        if (r < 70) mode = SDA_ACK;
        else if (r < 80) mode = SDA_ACK_ADDR;
        else if (r < 87) mode = SDA_ACK_DEV;
        else if (r < 93) mode = SDA_HIGH;
        else mode = SDA_LOW;
        while (ph != PH_IDLE) begin
            it = t_in'($urandom);
            if ($urandom_range(0, 24) == 0) begin
                it.op = 2'($urandom_range(1, 3));
            end else begin
                it.op     = OP_TICK;
                it.sda_in = line_level(mode) ^ ($urandom_range(0, 29) == 0);
            end
            offer(it);
            pace();
        end
        repeat ($urandom_range(0, 2)) begin
            it    = t_in'($urandom);
            it.op = OP_TICK;
            offer(it);
            pace();
        end
        if ($urandom_range(0, 9) == 0) drain();
    endtask

    initial begin : stimulus
        int txn;
        int r;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        cur_typed   = 1'b0;
        cur_want    = '0;
        hold_req    = 1'b0;
        steady      = 1'b0;
        errors      = 0;
        quiet_cycles = 0;
        work_items  = 0;
        ph          = PH_IDLE;
        stg         = SG_DEV;
        wcnt        = 0;
        bitn        = 0;
        nbytes      = 0;
        fill        = 0;
        len_q       = 0;
        shreg       = '0;
        dev_q       = '0;
        reg_q       = '0;
        rd          = 1'b0;
        err         = ST_OK;
        cfg_ticks   = WAIT_TICKS_RST;
        foreach (wbuf[i]) wbuf[i] = '0;

        // reset timing, busy-time loads and starts ignored, first start fails
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, 2, SDA_LOW, 1, IDLE_PINS));
        rows.push_back(row(OP_LOAD,  8'h00, 8'h00, 5'd0,  8'hFF, 1, SDA_LOW, 1, IDLE_PINS));
        rows.push_back(row(OP_WRITE, 8'h00, 8'hFF, 5'd31, 8'h00, 1, SDA_LOW, 1, BUSY_PINS));
        rows.push_back(row(OP_READ,  8'hFF, 8'h00, 5'd16, 8'h00, 1, SDA_LOW, 1, BUSY_PINS));
        rows.push_back(row(OP_LOAD,  8'h00, 8'h00, 5'd0,  8'h00, 1, SDA_LOW, 1, BUSY_PINS));
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, WAIT_TICKS_RST, SDA_LOW,
                           1, START_FAILED));
        rows.push_back(cfg_row(1));
        // fill past the end, then a saturated write
        rows.push_back(row(OP_LOAD,  8'h00, 8'h00, 5'd0,  8'h00, 1, SDA_HIGH));
        rows.push_back(row(OP_LOAD,  8'h00, 8'h00, 5'd0,  8'hFF, 1, SDA_HIGH));
        rows.push_back(row(OP_LOAD,  8'h00, 8'h00, 5'd0,  8'hA5, MAX_BYTES - 1, SDA_HIGH));
        rows.push_back(row(OP_WRITE, 8'hFE, 8'h00, 5'd31, 8'h00, 1, SDA_HIGH, 1, BUSY_PINS));
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, 0, SDA_ACK));
        // register nack, zero-length read, restart fail with unchecked ack
        rows.push_back(row(OP_WRITE, 8'h00, 8'hFF, 5'd1,  8'h00, 1, SDA_HIGH));
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, 0, SDA_ACK_DEV));
        rows.push_back(row(OP_READ,  8'hA1, 8'h3C, 5'd0,  8'h00, 1, SDA_HIGH));
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, 0, SDA_ACK));
        rows.push_back(row(OP_READ,  8'hA0, 8'h00, 5'd2,  8'h00, 1, SDA_HIGH));
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, 0, SDA_ACK_ADDR));
        // device nack on read and on write, then a full read
        rows.push_back(row(OP_READ,  8'h55, 8'hAA, 5'd16, 8'h00, 1, SDA_HIGH));
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, 0, SDA_HIGH));
        rows.push_back(row(OP_WRITE, 8'hAA, 8'h55, 5'd0,  8'h00, 1, SDA_HIGH));
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, 0, SDA_HIGH));
        rows.push_back(row(OP_READ,  8'h0F, 8'hF0, 5'd16, 8'h00, 1, SDA_HIGH));
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, 0, SDA_ACK));
        rows.push_back(cfg_row(0));
        rows.push_back(row(OP_READ,  8'h81, 8'h7E, 5'd3,  8'h00, 1, SDA_HIGH));
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, 0, SDA_ACK));
        rows.push_back(cfg_row(1023));
        rows.push_back(row(OP_WRITE, 8'h00, 8'h00, 5'd0,  8'h00, 1, SDA_LOW, 1, BUSY_PINS));
        rows.push_back(row(OP_TICK,  8'h00, 8'h00, 5'd0,  8'h00, 1023, SDA_LOW,
                           1, START_FAILED));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) run_row(rows[i]);

        work_items = 0;
        txn        = 0;
        hold_req   = 1'b1;
        while (work_items < ITEMS_TARGET) begin
            if (txn % 5 == 0) begin
                r = $urandom_range(0, 99);
                if (r < 45) write_wait_ticks(1);
                else if (r < 75) write_wait_ticks(2);
                else if (r < 85) write_wait_ticks(0);
                else if (r < 95) write_wait_ticks(3);
                else write_wait_ticks(5);
            end
            steady = ($urandom_range(0, 3) == 0);
            run_transaction();
            txn++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
rtl/core/i2crm_pkg.sv
rtl/core/i2crm_wbuf.sv
rtl/core/i2crm_ctrl.sv
rtl/core/i2c_register_master.sv
tb/tb_top.sv
